/* src/abad_pkg.sv */
`default_nettype none
package abad_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_RATIO_DEF = 16;

  // Reset rate ratio, expressed with 16 fraction bits.
  localparam int RATE_RESET_Q16 = 159187;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 8;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE  = 1'd1;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_DIV,
    BE_OUT
  } be_state_t;

endpackage
`default_nettype wire

/* src/abad_if.sv */
`default_nettype none
interface abad_in_if;
  logic                        valid;
  logic                        ready;
  logic [abad_pkg::SAMPLE_W-1:0] sample_raw;
  logic                        last;

  modport source (output valid, output sample_raw, output last, input ready);
  modport sink   (input valid, input sample_raw, input last, output ready);
endinterface

interface abad_out_if;
  logic                       valid;
  logic                       ready;
  logic [abad_pkg::OUT_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface
`default_nettype wire

/* src/abad_front.sv */
`default_nettype none
module abad_front #(
  parameter int  FRAC_BITS = abad_pkg::FRAC_BITS_DEF,
  parameter int  MAX_RATIO = abad_pkg::MAX_RATIO_DEF,
  localparam int RATIO_W   = FRAC_BITS + 4,
  localparam int SUM_W     = abad_pkg::SAMPLE_W + $clog2(MAX_RATIO) + 1,
  localparam int CNT_W     = $clog2(MAX_RATIO + 1),
  localparam int QW        = SUM_W + CNT_W + 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [abad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATIO_W-1:0]             cfg_data,
  abad_in_if.sink                             in_ch,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output logic [QW-1:0]                       push_data
);
  import abad_pkg::*;

  localparam int PH_W = FRAC_BITS + 5;
  localparam int RST_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int RST_DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam logic [63:0] RATE_RST = (64'(RATE_RESET_Q16) << RST_UP) >> RST_DN;
  localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << FRAC_BITS;

  logic [RATIO_W-1:0] ratio_r;
  logic               wide_r;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic               accept;
  logic [SUM_W-1:0]   samp;
  logic [PH_W-1:0]    phase_a, phase_b;
  logic [SUM_W-1:0]   sum_add;
  logic [CNT_W-1:0]   count_add;
  logic               ovf, close;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = push_ready;

  always_comb begin
    if (wide_r) begin
      samp = {{(SUM_W-SAMPLE_W){in_ch.sample_raw[SAMPLE_W-1]}}, in_ch.sample_raw};
    end else begin
      samp = {{(SUM_W-8){1'b0}}, in_ch.sample_raw[7:0]};
    end
  end

  always_comb begin
    phase_a   = (count_r == '0) ? phase_r + PH_W'(ratio_r) : phase_r;
    phase_b   = (phase_a >= PH_ONE) ? phase_a - PH_ONE : '0;
    sum_add   = sum_r + samp;
    count_add = count_r + CNT_W'(1);
    ovf       = (count_add == CNT_W'(MAX_RATIO));
    close     = (phase_b < PH_ONE) || ovf;

    phase_nxt = phase_b;
    sum_nxt   = sum_add;
    count_nxt = count_add;
    if (close) begin
      // An overflowing group keeps only the fraction of the phase.
      if (ovf) begin
        phase_nxt = phase_b & (PH_ONE - PH_W'(1));
      end
      sum_nxt   = '0;
      count_nxt = '0;
    end
    if (in_ch.last) begin
      phase_nxt = '0;
      sum_nxt   = '0;
      count_nxt = '0;
    end
  end

  assign push_valid = accept && close;
  assign push_data  = {wide_r, count_add, sum_add};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_W'(RATE_RST);
      wide_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RATE_RATIO: ratio_r <= cfg_data;
        CFG_WIDE_MODE:  wide_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      sum_r   <= '0;
      count_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last |=> count_r == '0 && phase_r == '0 && sum_r == '0)
    else $error("state not cleared after last sample");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(MAX_RATIO))
    else $error("group count reached its limit without closing");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !close && !in_ch.last |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("group count did not advance");

endmodule
`default_nettype wire

/* src/abad_queue.sv */
`default_nettype none
module abad_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);
  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   fill_r;
  logic         do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

/* src/abad_back.sv */
`default_nettype none
module abad_back #(
  parameter int  MAX_RATIO = abad_pkg::MAX_RATIO_DEF,
  localparam int SUM_W     = abad_pkg::SAMPLE_W + $clog2(MAX_RATIO) + 1,
  localparam int CNT_W     = $clog2(MAX_RATIO + 1),
  localparam int QW        = SUM_W + CNT_W + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire logic [QW-1:0] q_data,
  abad_out_if.source         out_ch
);
  import abad_pkg::*;

  localparam int DW = CNT_W + 8;
  localparam int SW = $clog2(SUM_W);

  be_state_t          state_r, state_nxt;
  logic [DW-1:0]      rem_r, div_r;
  logic [SUM_W-1:0]   dq_r;
  logic               neg_r;
  logic [SW-1:0]      step_r;
  logic [OUT_W-1:0]   res_r;

  logic               q_wide;
  logic [CNT_W-1:0]   q_cnt;
  logic [SUM_W-1:0]   q_sum;
  logic [DW:0]        shifted, trial;
  logic [DW-1:0]      rem_nxt;
  logic [SUM_W-1:0]   dq_nxt;
  logic               last_step;
  logic               load;

  assign {q_wide, q_cnt, q_sum} = q_data;
  assign load = q_valid && q_ready;

  // One restoring-division step per cycle on the magnitude of the sum.
  always_comb begin
    shifted = {rem_r, dq_r[SUM_W-1]};
    trial   = shifted - {1'b0, div_r};
    if (!trial[DW]) begin
      rem_nxt = trial[DW-1:0];
      dq_nxt  = {dq_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DW-1:0];
      dq_nxt  = {dq_r[SUM_W-2:0], 1'b0};
    end
    last_step = (step_r == SW'(SUM_W - 1));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_IDLE: if (q_valid) state_nxt = BE_DIV;
      BE_DIV:  if (last_step) state_nxt = BE_OUT;
      BE_OUT:  if (out_ch.ready) state_nxt = BE_IDLE;
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_comb begin
    q_ready      = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      BE_IDLE: q_ready = 1'b1;
      BE_OUT:  out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_ch.out_sample = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dq_r   <= q_sum[SUM_W-1] ? SUM_W'(-q_sum) : q_sum;
      neg_r  <= q_sum[SUM_W-1];
      div_r  <= q_wide ? {q_cnt, 8'd0} : {8'd0, q_cnt};
      rem_r  <= '0;
      step_r <= '0;
    end else if (state_r == BE_DIV) begin
      dq_r   <= dq_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + SW'(1);
      if (last_step) begin
        // Truncation toward zero: negate the magnitude quotient.
        res_r <= neg_r ? OUT_W'(~dq_nxt[OUT_W-1:0] + OUT_W'(1)) : dq_nxt[OUT_W-1:0];
      end
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BE_DIV |-> rem_r < div_r)
    else $error("partial remainder not below divisor");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> state_r == BE_DIV && step_r == '0)
    else $error("divide did not start after load");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BE_DIV |-> div_r != '0)
    else $error("zero divisor in divide");

endmodule
`default_nettype wire

/* src/audio_box_average_decimator_core.sv */
// Box-filter decimator for one stream of audio samples.
// in_ch carries one source sample per transfer (sample_raw, last); out_ch
// carries one 8-bit average per closed group (out_sample). Both channels
// transfer when valid and ready are high at a rising clock edge.
// The cfg port writes rate_ratio (index 0, Q4.FRAC_BITS) and wide_mode
// (index 1) at any edge with cfg_wr_en high. The user must write them
// only while the block is idle; the block itself does not enforce this.
// The front end takes one sample per cycle while the queue has room and
// updates the phase, sum and count in that cycle. A closed group enters a
// two-entry queue, and the back end divides it with a bit-serial restoring
// divider, one quotient bit per cycle over the sum width (21 bits by
// default). out_ch.valid rises once all divide steps are done; the back
// end takes no new group until its result has transferred. When out_ch
// stalls, the result holds in the output register, the queue fills, and
// in_ch.ready drops once both queue entries are taken. Synchronous reset
// clears the phase, sum, count and queue, returns the divider to idle,
// and sets rate_ratio to its default and wide_mode to 8-bit samples.
`default_nettype none
module audio_box_average_decimator_core #(
  parameter int  FRAC_BITS = abad_pkg::FRAC_BITS_DEF,
  parameter int  MAX_RATIO = abad_pkg::MAX_RATIO_DEF,
  localparam int RATIO_W   = FRAC_BITS + 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [abad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATIO_W-1:0]             cfg_data,
  abad_in_if.sink                             in_ch,
  abad_out_if.source                          out_ch
);
  import abad_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_RATIO) + 1;
  localparam int CNT_W = $clog2(MAX_RATIO + 1);
  localparam int QW    = SUM_W + CNT_W + 1;

  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  abad_front #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_RATIO (MAX_RATIO)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  abad_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  abad_back #(
    .MAX_RATIO (MAX_RATIO)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_data  (pop_data),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
module tb;
  import abad_pkg::*;

  localparam int RATIO_W = FRAC_BITS_DEF + 4;
  localparam int unsigned PHASE_ONE = 32'd1 << FRAC_BITS_DEF;
  localparam int unsigned PHASE_MASK = (32'd1 << (FRAC_BITS_DEF + 5)) - 1;
  localparam int unsigned RATIO_MAX = (32'd1 << RATIO_W) - 1;
  localparam int SETTLE_CYCLES = 40;

  // Tracks phase, sum and count of the open group and queues the averages
  // that closed groups must produce.
  class decim_scoreboard;
    int unsigned ratio;
    logic wide;
    int unsigned phase;
    int sum;
    int unsigned count;
    logic [OUT_W-1:0] averages_due[$];
    int errors;

    function new();
      ratio = RATE_RESET_Q16;
      wide = 1'b0;
      errors = 0;
      clear_group();
    endfunction

    function void clear_group();
      phase = 0;
      sum = 0;
      count = 0;
    endfunction

    function logic [OUT_W-1:0] group_average();
      int div;
      int q;
      div = count;
      if (wide) div = div * 256;
      if (div == 0) div = 1;
      q = sum / div;
      return q[OUT_W-1:0];
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw, logic lst);
      int v;
      logic overflow;
      if (count == 0) phase = (phase + ratio) & PHASE_MASK;
      if (wide) v = int'($signed(raw));
      else v = int'(raw[7:0]);
      sum += v;
      count++;
      // Below one the phase cannot go negative; it sticks at zero.
      if (phase >= PHASE_ONE) phase -= PHASE_ONE;
      else phase = 0;
      overflow = (count >= MAX_RATIO_DEF);
      if (phase < PHASE_ONE || overflow) begin
        averages_due.push_back(group_average());
        if (overflow) phase &= PHASE_ONE - 1;
        sum = 0;
        count = 0;
      end
      if (lst) clear_group();
    endfunction

    function void check_average(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (averages_due.size() == 0) begin
        $display("%0t: unexpected average, expected none, got %02h", $time, got);
        errors++;
      end else begin
        want = averages_due.pop_front();
        if (got !== want) begin
          $display("%0t: average mismatch, expected %02h, got %02h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return averages_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATIO_W-1:0] cfg_data;

  abad_in_if in_ch();
  abad_out_if out_ch();

  decim_scoreboard board = new();
  bit steady;
  int stall_left;

  audio_box_average_decimator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'h00FF;
      5: return 16'h0080;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    case ($urandom_range(0, 7))
      0: return RATIO_W'(PHASE_ONE);
      1: return RATIO_W'(RATIO_MAX);
      2: return RATIO_W'($urandom_range(0, PHASE_ONE - 1));
      6: return RATIO_W'($urandom_range(PHASE_ONE, RATIO_MAX));
      7: return RATIO_W'(RATE_RESET_Q16);
      default: return RATIO_W'($urandom_range(PHASE_ONE, 4 * PHASE_ONE));
    endcase
  endfunction

  // Result side: random backpressure, none while steady is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_average(out_ch.out_sample);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_raw <= raw;
    in_ch.last <= lst;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(raw, lst);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_RATE_RATIO) board.ratio = 32'(data);
    else board.wide = data[0];
  endtask

  // Registers change only once every average due has arrived and the
  // divider has had time to finish.
  task automatic configure(input bit do_rate, input logic [RATIO_W-1:0] rate,
                           input bit do_mode, input logic mode);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (do_rate) write_reg(CFG_RATE_RATIO, rate);
    if (do_mode) write_reg(CFG_WIDE_MODE, {{(RATIO_W-1){1'b0}}, mode});
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int sent;
    int len;
    int waited;
    logic lst;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_raw = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    stall_left = 0;
    steady = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: pairs of 8-bit samples, clip ends on an open group.
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFF80, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h1234, 1'b1);

    // Largest ratio: a group closes after 15 samples; last opens a new one.
    configure(1'b1, RATIO_W'(RATIO_MAX), 1'b1, 1'b1);
    for (int k = 0; k < MAX_RATIO_DEF; k++) send_sample(16'h8000, k == MAX_RATIO_DEF - 1);

    // A zero ratio closes a group on every sample.
    configure(1'b1, '0, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);

    // Switch to wide samples while a narrow group is still open.
    configure(1'b1, RATIO_W'(3 * PHASE_ONE), 1'b1, 1'b0);
    send_sample(16'h00C8, 1'b0);
    configure(1'b0, '0, 1'b1, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b1);

    sent = 0;
    while (sent < 1450) begin
      steady = ($urandom_range(0, 5) == 0);
      configure($urandom_range(0, 3) != 0, pick_ratio(),
                $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      len = $urandom_range(10, 80);
      for (int k = 0; k < len; k++) begin
        lst = ($urandom_range(0, 39) == 0) || (k == len - 1 && $urandom_range(0, 1) == 1);
        send_sample(pick_sample(), lst);
      end
      sent += len;
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0t: %0d averages never arrived, oldest expected %02h, got none",
               $time, board.pending(), board.averages_due[0]);
      board.errors++;
    end

    if (board.errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

/* audio_box_average_decimator_core.f */
src/abad_pkg.sv
src/abad_if.sv
src/abad_front.sv
src/abad_queue.sv
src/abad_back.sv
src/audio_box_average_decimator_core.sv
tb/sv/tb.sv
